FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the framebuffer blitter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while the given active-low reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Same, on the block's own clock and reset.
`define ASSERT_DEF(lbl, prop) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

FILE: sv/mpfb_pkg.sv
// ----------------------------------------------------------------------------
// mpfb_pkg
// Types and constants shared by the framebuffer blitter modules.
// ----------------------------------------------------------------------------
package mpfb_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 32;
  localparam int STORE_BYTES   = SCREEN_WIDTH * SCREEN_HEIGHT / 8;
  localparam int STORE_AW      = $clog2(STORE_BYTES);

  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  localparam int PADDR_W = 5;

  // request codes
  localparam logic [2:0] REQ_PLOT   = 3'd0;
  localparam logic [2:0] REQ_BLIT   = 3'd1;
  localparam logic [2:0] REQ_READ   = 3'd2;
  localparam logic [2:0] REQ_CLEAR  = 3'd3;
  localparam logic [2:0] REQ_FILL   = 3'd4;
  localparam logic [2:0] REQ_INVERT = 3'd5;

  // register indexes (word address)
  localparam logic [2:0] REG_BLIT_LEFT   = 3'd0;
  localparam logic [2:0] REG_BLIT_TOP    = 3'd1;
  localparam logic [2:0] REG_BLIT_WIDTH  = 3'd2;
  localparam logic [2:0] REG_BLIT_HEIGHT = 3'd3;
  localparam logic [2:0] REG_BLIT_INK    = 3'd4;

  typedef enum logic [2:0] {
    OP_DRAW   = 3'd0,
    OP_READ   = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_FILL   = 3'd3,
    OP_INVERT = 3'd4
  } op_e;

  // One queued command. Draw covers both plot and blit: up to cnt pixels
  // from col onward in one row, pixel k colored by bits[7-k].
  typedef struct packed {
    op_e        op;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] bits;
    logic [3:0] cnt;
    logic       ink;
    logic [8:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [7:0] left;
    logic [7:0] top;
    logic [7:0] width;
    logic [7:0] height;
    logic       ink;
  } blit_cfg_t;

endpackage

FILE: sv/mpfb_cmd_fifo.sv
// ----------------------------------------------------------------------------
// mpfb_cmd_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module mpfb_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mpfb_pkg::cmd_t data_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output mpfb_pkg::cmd_t data_o
);
  import mpfb_pkg::*;

  localparam int AW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CW = $clog2(CMD_DEPTH + 1);

  cmd_t          mem_q [CMD_DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q + CW'(push_i) - CW'(pop_i);
    if (push_i) begin
      wr_d = (wr_q == AW'(CMD_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(CMD_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: sv/mpfb_front.sv
// ----------------------------------------------------------------------------
// mpfb_front
// Classifies requests into commands and keeps the blit cursor.
// ----------------------------------------------------------------------------
module mpfb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [2:0]          req_type_i,
  input  logic [7:0]          pixel_col_i,
  input  logic [7:0]          pixel_row_i,
  input  logic                pixel_on_i,
  input  logic [7:0]          bitmap_byte_i,
  input  logic [8:0]          read_index_i,
  input  mpfb_pkg::blit_cfg_t cfg_i,
  input  logic                cfg_wr_i,
  output logic                enq_o,
  output mpfb_pkg::cmd_t      cmd_o
);
  import mpfb_pkg::*;

  logic [7:0] row_cnt_q, row_cnt_d;
  logic [4:0] byte_cnt_q, byte_cnt_d;

  logic [5:0] bpr;
  logic       bmp_empty, restart, keep;
  logic [7:0] row_eff, first, remain;
  logic [4:0] byte_eff;
  logic [3:0] npix;
  logic [5:0] byte_nx;
  logic [8:0] row_nx;

  always_comb begin
    bpr       = 6'((9'(cfg_i.width) + 9'd7) >> 3);
    bmp_empty = (cfg_i.width == '0) || (cfg_i.height == '0);
    restart   = (row_cnt_q >= cfg_i.height) || ({1'b0, byte_cnt_q} >= bpr);
    row_eff   = restart ? '0 : row_cnt_q;
    byte_eff  = restart ? '0 : byte_cnt_q;
    first     = {byte_eff, 3'b000};
    remain    = cfg_i.width - first;
    npix      = (remain >= 8'd8) ? 4'd8 : remain[3:0];

    // cursor advance
    byte_nx    = {1'b0, byte_eff} + 6'd1;
    row_nx     = {1'b0, row_eff} + 9'd1;
    byte_cnt_d = byte_nx[4:0];
    row_cnt_d  = row_eff;
    if (byte_nx >= bpr) begin
      byte_cnt_d = '0;
      row_cnt_d  = (row_nx >= {1'b0, cfg_i.height}) ? '0 : row_nx[7:0];
    end
  end

  always_comb begin
    keep       = 1'b1;
    cmd_o.op   = OP_DRAW;
    cmd_o.col  = pixel_col_i;
    cmd_o.row  = pixel_row_i;
    cmd_o.bits = 8'h80;
    cmd_o.cnt  = 4'd1;
    cmd_o.ink  = pixel_on_i;
    cmd_o.idx  = read_index_i;
    case (req_type_i)
      REQ_PLOT: begin
      end
      REQ_BLIT: begin
        keep       = !bmp_empty;
        cmd_o.col  = cfg_i.left + first;
        cmd_o.row  = cfg_i.top + row_eff;
        cmd_o.bits = bitmap_byte_i;
        cmd_o.cnt  = npix;
        cmd_o.ink  = cfg_i.ink;
      end
      REQ_READ:   cmd_o.op = OP_READ;
      REQ_CLEAR:  cmd_o.op = OP_CLEAR;
      REQ_FILL:   cmd_o.op = OP_FILL;
      REQ_INVERT: cmd_o.op = OP_INVERT;
      default:    keep = 1'b0;
    endcase
  end

  assign enq_o = accept_i && keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q  <= '0;
      byte_cnt_q <= '0;
    end else if (cfg_wr_i) begin
      row_cnt_q  <= '0;
      byte_cnt_q <= '0;
    end else if (accept_i && (req_type_i == REQ_BLIT) && !bmp_empty) begin
      row_cnt_q  <= row_cnt_d;
      byte_cnt_q <= byte_cnt_d;
    end
  end

endmodule

FILE: sv/mpfb_back.sv
// ----------------------------------------------------------------------------
// mpfb_back
// Framebuffer store and its read-modify-write engine, plus result queue.
// ----------------------------------------------------------------------------
module mpfb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  mpfb_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           init_o,
  output logic           res_empty_o,
  output logic [7:0]     res_data_o,
  input  logic           res_pop_i
);
  import mpfb_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT = 3'b001,
    ST_IDLE = 3'b010,
    ST_RUN  = 3'b100
  } state_e;

  localparam int OAW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int OCW = $clog2(OUT_DEPTH + 1);

  state_e              state_q, state_d;
  cmd_t                cur_q;
  logic [STORE_AW-1:0] slot_q, slot_d;

  logic [7:0]          mem_q [STORE_BYTES];
  logic [7:0]          rdata_q;

  // write-back stage
  logic                s2_valid_q;
  op_e                 s2_op_q;
  logic [STORE_AW-1:0] s2_addr_q;
  logic [2:0]          s2_bitpos_q;
  logic                s2_val_q;
  logic                s2_oob_q;

  // result queue
  logic [7:0]          out_mem_q [OUT_DEPTH];
  logic [OAW-1:0]      out_wr_q, out_rd_q;
  logic [OCW-1:0]      out_cnt_q;

  logic                start, is_last, iss_en, iss_val, iss_oob;
  logic [STORE_AW-1:0] iss_addr;
  logic [2:0]          k;
  logic [7:0]          col;

  logic                we, out_push, out_pop;
  logic [STORE_AW-1:0] waddr;
  logic [7:0]          wdata, mask, mod;

  // a read still in write-back counts against the result queue room
  assign start     = (state_q == ST_IDLE) && cmd_valid_i &&
                     ((cmd_i.op != OP_READ) ||
                      ((out_cnt_q + OCW'(out_push)) != OCW'(OUT_DEPTH)));
  assign cmd_pop_o = start;
  assign init_o    = (state_q == ST_INIT);

  // slot issue
  always_comb begin
    k        = slot_q[2:0];
    col      = cur_q.col + 8'(k);
    iss_en   = 1'b1;
    iss_val  = 1'b0;
    iss_oob  = 1'b0;
    iss_addr = slot_q;
    is_last  = (slot_q == STORE_AW'(STORE_BYTES - 1));
    case (cur_q.op)
      OP_DRAW: begin
        iss_en   = (9'(col) < 9'(SCREEN_WIDTH)) && (9'(cur_q.row) < 9'(SCREEN_HEIGHT));
        iss_val  = cur_q.bits[3'd7 - k] ? cur_q.ink : !cur_q.ink;
        iss_addr = STORE_AW'(32'(col) + 32'(cur_q.row[7:3]) * 32'(SCREEN_WIDTH));
        is_last  = ((4'(k) + 4'd1) == cur_q.cnt);
      end
      OP_READ: begin
        iss_addr = STORE_AW'(cur_q.idx);
        iss_oob  = (32'(cur_q.idx) >= 32'(STORE_BYTES));
        is_last  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    case (state_q)
      ST_INIT: begin
        slot_d = slot_q + 1'b1;
        if (slot_q == STORE_AW'(STORE_BYTES - 1)) begin
          slot_d  = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          slot_d  = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        slot_d = slot_q + 1'b1;
        if (is_last) begin
          slot_d  = '0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        slot_d  = '0;
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      slot_q     <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      slot_q     <= slot_d;
      s2_valid_q <= (state_q == ST_RUN) && iss_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      cur_q <= cmd_i;
    end
    s2_op_q     <= cur_q.op;
    s2_addr_q   <= iss_addr;
    s2_bitpos_q <= cur_q.row[2:0];
    s2_val_q    <= iss_val;
    s2_oob_q    <= iss_oob;
  end

  // modify
  always_comb begin
    mask = 8'd1 << s2_bitpos_q;
    case (s2_op_q)
      OP_DRAW:   mod = s2_val_q ? (rdata_q | mask) : (rdata_q & ~mask);
      OP_CLEAR:  mod = 8'h00;
      OP_FILL:   mod = 8'hFF;
      OP_INVERT: mod = ~rdata_q;
      default:   mod = rdata_q;
    endcase
  end

  assign we       = init_o || (s2_valid_q && (s2_op_q != OP_READ));
  assign waddr    = init_o ? slot_q : s2_addr_q;
  assign wdata    = init_o ? 8'h00 : mod;
  assign out_push = s2_valid_q && (s2_op_q == OP_READ);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[iss_addr];
  end

  // result queue
  assign out_pop     = res_pop_i && (out_cnt_q != '0);
  assign res_empty_o = (out_cnt_q == '0);
  assign res_data_o  = out_mem_q[out_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= '0;
      out_rd_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      out_cnt_q <= out_cnt_q + OCW'(out_push) - OCW'(out_pop);
      if (out_push) begin
        out_wr_q <= (out_wr_q == OAW'(OUT_DEPTH - 1)) ? '0 : out_wr_q + 1'b1;
      end
      if (out_pop) begin
        out_rd_q <= (out_rd_q == OAW'(OUT_DEPTH - 1)) ? '0 : out_rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_mem_q[out_wr_q] <= s2_oob_q ? 8'h00 : rdata_q;
    end
  end

endmodule

FILE: sv/mono_page_framebuffer_blitter_unit.sv
// ----------------------------------------------------------------------------
// mono_page_framebuffer_blitter_unit
// Page-organized one-bit framebuffer with plot, bitmap blit, clear, fill,
// invert and byte read.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  request  | push / full            | req_type_i, pixel_*_i, bitmap_byte_i,
//           |                        | read_index_i
//  result   | pop / empty            | read_data_o (reads only)
//  config   | psel, penable, pwrite, | paddr (4*index), pwdata, prdata
//           | pready (always high)   |
//
//  Engine: the back engine picks up a command while idle, then makes one
//  store access per slot: plot and read 1, blit byte 1 to 8 (pixels in the
//  byte), clear/fill/invert one per store byte (512). Write-back follows
//  each read in the next cycle through the single store port pair.
//  Reset: the store is cleared by a sweep over all 512 store bytes; full
//  stays high meanwhile. Config registers can be written during the sweep.
//  Stalls: a two-entry command queue decouples request transfers from the
//  engine; a two-entry result queue lets the engine run while results wait.
//  A read waits for room in the result queue before it starts.
//
module mono_page_framebuffer_blitter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request queue side
  input  logic                          push,
  output logic                          full,
  input  logic [2:0]                    req_type_i,
  input  logic [7:0]                    pixel_col_i,
  input  logic [7:0]                    pixel_row_i,
  input  logic                          pixel_on_i,
  input  logic [7:0]                    bitmap_byte_i,
  input  logic [8:0]                    read_index_i,
  // result queue side
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    read_data_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mpfb_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import mpfb_pkg::*;

  blit_cfg_t  cfg_q;
  logic       cfg_wr, reg_wr;
  logic [2:0] reg_idx;

  logic       accept, enq, fifo_full, fifo_empty, cmd_pop, init_busy;
  cmd_t       enq_cmd, head_cmd;

  // ---------------- configuration registers ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_wr = 1'b0;
    prdata = '0;
    case (reg_idx)
      REG_BLIT_LEFT: begin
        cfg_wr = reg_wr;
        prdata = 32'(cfg_q.left);
      end
      REG_BLIT_TOP: begin
        cfg_wr = reg_wr;
        prdata = 32'(cfg_q.top);
      end
      REG_BLIT_WIDTH: begin
        cfg_wr = reg_wr;
        prdata = 32'(cfg_q.width);
      end
      REG_BLIT_HEIGHT: begin
        cfg_wr = reg_wr;
        prdata = 32'(cfg_q.height);
      end
      REG_BLIT_INK: begin
        cfg_wr = reg_wr;
        prdata = 32'(cfg_q.ink);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left   <= '0;
      cfg_q.top    <= '0;
      cfg_q.width  <= '0;
      cfg_q.height <= '0;
      cfg_q.ink    <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BLIT_LEFT:   cfg_q.left   <= pwdata[7:0];
        REG_BLIT_TOP:    cfg_q.top    <= pwdata[7:0];
        REG_BLIT_WIDTH:  cfg_q.width  <= pwdata[7:0];
        REG_BLIT_HEIGHT: cfg_q.height <= pwdata[7:0];
        REG_BLIT_INK:    cfg_q.ink    <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // ---------------- front: classify + blit cursor ----------------
  // Dropped requests (unused codes, blit with an empty bitmap) still
  // complete their transfer; they just never reach the queue.
  assign full   = fifo_full || init_busy;
  assign accept = push && !full;

  mpfb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .req_type_i    (req_type_i),
    .pixel_col_i   (pixel_col_i),
    .pixel_row_i   (pixel_row_i),
    .pixel_on_i    (pixel_on_i),
    .bitmap_byte_i (bitmap_byte_i),
    .read_index_i  (read_index_i),
    .cfg_i         (cfg_q),
    .cfg_wr_i      (cfg_wr),
    .enq_o         (enq),
    .cmd_o         (enq_cmd)
  );

  // ---------------- command queue ----------------
  mpfb_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (enq),
    .data_i  (enq_cmd),
    .pop_i   (cmd_pop),
    .full_o  (fifo_full),
    .empty_o (fifo_empty),
    .data_o  (head_cmd)
  );

  // ---------------- back: store engine ----------------
  mpfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!fifo_empty),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (cmd_pop),
    .init_o      (init_busy),
    .res_empty_o (empty),
    .res_data_o  (read_data_o),
    .res_pop_i   (pop)
  );

endmodule

FILE: sv/mpfb_checker.sv
// ----------------------------------------------------------------------------
// mpfb_checker
// Port-level checks of the framebuffer blitter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpfb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          push,
  input logic                          full,
  input logic [2:0]                    req_type_i,
  input logic                          empty,
  input logic                          pop,
  input logic [7:0]                    read_data_o,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [mpfb_pkg::PADDR_W-1:0]  paddr,
  input logic [31:0]                   pwdata,
  input logic [31:0]                   prdata
);
  import mpfb_pkg::*;

  logic [3:0] rd_pend_q;
  logic       rd_in, rd_out;

  assign rd_in  = push && !full && (req_type_i == REQ_READ);
  assign rd_out = pop && !empty;

  // reads transferred in but not yet popped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= '0;
    end else begin
      rd_pend_q <= rd_pend_q + 4'(rd_in) - 4'(rd_out);
    end
  end

  // a result only ever follows a read request
  `ASSERT_DEF(a_no_spurious_result, !empty |-> (rd_pend_q != '0))

  // a waiting result holds until popped
  `ASSERT_DEF(a_result_holds, (!empty && !pop) |=> (!empty && $stable(read_data_o)))

  // the store clear after reset keeps requests out
  `ASSERT_DEF(a_init_blocks, !$past(rst_ni) |-> full)

  // a written blit_left reads back
  `ASSERT_DEF(a_left_readback,
    (psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_BLIT_LEFT)) ##1
    (psel && !pwrite && (paddr[PADDR_W-1:2] == REG_BLIT_LEFT))
    |-> (prdata[7:0] == $past(pwdata[7:0])))

endmodule

bind mono_page_framebuffer_blitter_unit mpfb_checker u_mpfb_checker (.*);
